### sv/ieee1284_host_nibble_sequencer_assert.svh
// Assertion macros for the IEEE 1284 host nibble sequencer.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef IEEE1284_HOST_NIBBLE_SEQUENCER_ASSERT_SVH
`define IEEE1284_HOST_NIBBLE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define IHNS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ihns assertion failed");
// Check that a condition never holds
`define IHNS_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ihns forbidden condition seen");
`else
`define IHNS_ASSERT(lbl, prop)
`define IHNS_ASSERT_NEVER(lbl, cond)
`endif

`endif

### sv/ihns_pkg.sv
// Shared types and constants of the IEEE 1284 host nibble sequencer.
// No dependencies.
package ihns_pkg;

	// Command field of an input word
	typedef enum logic [1:0] {
		CMD_TICK        = 2'd0,
		CMD_NEGOTIATE   = 2'd1,
		CMD_TERMINATE   = 2'd2,
		CMD_NIBBLE_READ = 2'd3
	} cmd_e;

	// Completion codes
	typedef enum logic [1:0] {
		RES_OK        = 2'd0,
		RES_NOT_1284  = 2'd1,
		RES_SEL_LOW   = 2'd2,
		RES_REJ_BUSY  = 2'd3
	} res_code_e;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST1,
		PH_RST2,
		PH_NEG1,
		PH_NEG2,
		PH_NEG3,
		PH_TRM1,
		PH_TRM2,
		PH_NIB_HI,
		PH_NIB_LO
	} phase_e;

	// Configuration register indexes
	localparam logic [1:0] REG_SHORT_DELAY = 2'd0;
	localparam logic [1:0] REG_RESET_DELAY = 2'd1;

	// Control register bits and values
	localparam logic [3:0] CTRL_AUTOFD   = 4'h2;
	localparam logic [3:0] CTRL_SELECTIN = 4'h8;
	localparam logic [3:0] CTRL_RESET    = 4'hc;
	localparam logic [3:0] CTRL_NEG_INIT = 4'h8;
	localparam logic [3:0] CTRL_LOW2     = 4'h3;

	// Status register masks
	localparam logic [7:0] STAT_ID_MASK  = 8'h78;
	localparam logic [7:0] STAT_ID_VALUE = 8'h38;
	localparam logic [7:0] STAT_SELECT   = 8'h10;
	localparam logic [7:0] STAT_NFAULT   = 8'h08;

	// Reset values of the delay registers
	localparam logic [15:0] SHORT_DELAY_RESET = 16'd1000;
	localparam logic [15:0] RESET_DELAY_RESET = 16'd5000;

	// Classified input word as held in the queue
	typedef struct packed {
		cmd_e        kind;
		logic        is_cmd;
		logic [7:0]  mode_byte;
		logic [15:0] byte_count;
		logic [7:0]  status_lines;
	} item_t;

	// One result word
	typedef struct packed {
		logic [3:0]  ctrl_lines;
		logic [7:0]  data_lines;
		logic [7:0]  rx_byte;
		logic        rx_valid;
		logic        done_res;
		res_code_e   result_code;
		logic [15:0] bytes_read;
		logic        busy_res;
	} result_t;

endpackage

### sv/ieee1284_host_nibble_sequencer.sv
// Top level of the IEEE 1284 host nibble sequencer: front end with queue and
// sequencer back end. Depends on ihns_pkg, ihns_front and ihns_back.
//
//  channel   handshake            payload
//  input     in_valid / in_stall  cmd, mode_byte, byte_count, status_lines
//  output    out_valid/out_stall  ctrl_lines .. busy_res, one word per input
//  config    cfg_we               cfg_index, cfg_wdata
//
// One input word is taken each cycle while in_stall is low; its result word is
// registered as the sequencer pops it from the two-entry queue, at an edge later
// than its accepting one; unstalled, one word and state update each cycle.
// Reset returns the control register to 0xc, the delays to their defaults
// and empties the queue and the result register.
// A stalled output holds its word; the queue fills and then stalls the input.
module ieee1284_host_nibble_sequencer #(
	parameter int COUNT_BITS = 16,
	parameter int DELAY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  mode_byte,
	input  logic [15:0] byte_count,
	input  logic [7:0]  status_lines,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  ctrl_lines,
	output logic [7:0]  data_lines,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic        done_res,
	output logic [1:0]  result_code,
	output logic [15:0] bytes_read,
	output logic        busy_res
);

	logic              q_valid;
	logic              q_pop;
	ihns_pkg::item_t   q_item;
	ihns_pkg::result_t res;

	ihns_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.mode_byte    (mode_byte),
		.byte_count   (byte_count),
		.status_lines (status_lines),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	ihns_back #(
		.COUNT_BITS (COUNT_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// Unpack the result word onto the ports
	assign ctrl_lines  = res.ctrl_lines;
	assign data_lines  = res.data_lines;
	assign rx_byte     = res.rx_byte;
	assign rx_valid    = res.rx_valid;
	assign done_res    = res.done_res;
	assign result_code = res.result_code;
	assign bytes_read  = res.bytes_read;
	assign busy_res    = res.busy_res;

endmodule

### sv/ihns_front.sv
// Front end: accepts input words, classifies the command and holds them in a
// two-entry queue for the sequencer. Depends on ihns_pkg.
module ihns_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [7:0]          mode_byte,
	input  logic [15:0]         byte_count,
	input  logic [7:0]          status_lines,
	output logic                q_valid,
	output ihns_pkg::item_t     q_item,
	input  logic                q_pop
);

	ihns_pkg::item_t q_mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	ihns_pkg::item_t new_item;

	// Classify the incoming word
	always_comb begin
		new_item.kind         = ihns_pkg::cmd_e'(cmd);
		new_item.is_cmd       = (ihns_pkg::cmd_e'(cmd) != ihns_pkg::CMD_TICK);
		new_item.mode_byte    = mode_byte;
		new_item.byte_count   = byte_count;
		new_item.status_lines = status_lines;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/ihns_back.sv
// Back end: the negotiation, terminate and nibble read sequencer with its
// delay registers and the result register. Depends on ihns_pkg and the
// assertion header.
`include "ieee1284_host_nibble_sequencer_assert.svh"

module ihns_back #(
	parameter int COUNT_BITS = 16,
	parameter int DELAY_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                q_valid,
	input  ihns_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ihns_pkg::result_t   res
);

	// Configuration
	logic [15:0] short_q;
	logic [15:0] reset_q;

	// Sequencer state
	ihns_pkg::phase_e      phase_q, phase_d;
	logic [3:0]            ctrl_q, ctrl_d;
	logic [7:0]            data_q, data_d;
	logic [DELAY_BITS-1:0] wait_q, wait_d;
	logic [COUNT_BITS:0]   idx_q, idx_d;
	logic [3:0]            lown_q, lown_d;
	logic [COUNT_BITS-1:0] tgt_q, tgt_d;

	// Result register
	logic                  out_valid_q;
	ihns_pkg::result_t     res_q;
	ihns_pkg::result_t     res_d;

	// Helpers
	logic [31:0]           short_ext, reset_ext, count_ext, br_ext;
	logic [DELAY_BITS-1:0] short_ld, reset_ld;
	logic [COUNT_BITS-1:0] count_ld;
	logic [3:0]            nib;
	logic [7:0]            s;
	logic                  start_nib;

	assign short_ext = 32'(short_q);
	assign reset_ext = 32'(reset_q);
	assign count_ext = 32'(q_item.byte_count);
	assign short_ld  = short_ext[DELAY_BITS-1:0];
	assign reset_ld  = reset_ext[DELAY_BITS-1:0];
	assign count_ld  = count_ext[COUNT_BITS-1:0];
	assign s         = q_item.status_lines;
	assign nib       = {~s[7], s[5:3]};

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= ihns_pkg::SHORT_DELAY_RESET;
			reset_q <= ihns_pkg::RESET_DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ihns_pkg::REG_SHORT_DELAY: short_q <= cfg_wdata;
				ihns_pkg::REG_RESET_DELAY: reset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Step the sequence by one word
	always_comb begin
		phase_d   = phase_q;
		ctrl_d    = ctrl_q;
		data_d    = data_q;
		wait_d    = wait_q;
		idx_d     = idx_q;
		lown_d    = lown_q;
		tgt_d     = tgt_q;
		start_nib = 1'b0;
		res_d.rx_byte     = 8'd0;
		res_d.rx_valid    = 1'b0;
		res_d.done_res    = 1'b0;
		res_d.result_code = ihns_pkg::RES_OK;

		if (phase_q == ihns_pkg::PH_IDLE) begin
			case (q_item.kind)
				ihns_pkg::CMD_NEGOTIATE: begin
					ctrl_d  = ihns_pkg::CTRL_NEG_INIT;
					data_d  = q_item.mode_byte;
					wait_d  = reset_ld;
					phase_d = ihns_pkg::PH_RST1;
				end
				ihns_pkg::CMD_TERMINATE: begin
					ctrl_d  = (ctrl_q & ~ihns_pkg::CTRL_AUTOFD) | ihns_pkg::CTRL_SELECTIN;
					wait_d  = short_ld;
					phase_d = ihns_pkg::PH_TRM1;
				end
				ihns_pkg::CMD_NIBBLE_READ: begin
					tgt_d = count_ld;
					idx_d = '0;
					if (count_ld == '0) begin
						res_d.done_res = 1'b1;
					end else begin
						start_nib = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (q_item.is_cmd) begin
			res_d.result_code = ihns_pkg::RES_REJ_BUSY;
		end else if (wait_q > DELAY_BITS'(1)) begin
			wait_d = wait_q - DELAY_BITS'(1);
		end else begin
			case (phase_q)
				ihns_pkg::PH_RST1: begin
					ctrl_d  = ihns_pkg::CTRL_RESET;
					wait_d  = reset_ld;
					phase_d = ihns_pkg::PH_RST2;
				end
				ihns_pkg::PH_RST2: begin
					ctrl_d  = (ctrl_q & ~ihns_pkg::CTRL_LOW2) | ihns_pkg::CTRL_SELECTIN;
					wait_d  = short_ld;
					phase_d = ihns_pkg::PH_NEG1;
				end
				ihns_pkg::PH_NEG1: begin
					ctrl_d  = (ctrl_q & ~ihns_pkg::CTRL_SELECTIN) | ihns_pkg::CTRL_AUTOFD;
					wait_d  = short_ld;
					phase_d = ihns_pkg::PH_NEG2;
				end
				ihns_pkg::PH_NEG2: begin
					if ((s & ihns_pkg::STAT_ID_MASK) != ihns_pkg::STAT_ID_VALUE) begin
						ctrl_d  = (ctrl_q & ~ihns_pkg::CTRL_AUTOFD) | ihns_pkg::CTRL_SELECTIN;
						phase_d = ihns_pkg::PH_IDLE;
						res_d.done_res    = 1'b1;
						res_d.result_code = ihns_pkg::RES_NOT_1284;
					end else begin
						ctrl_d  = ctrl_q & ~ihns_pkg::CTRL_LOW2;
						wait_d  = short_ld;
						phase_d = ihns_pkg::PH_NEG3;
					end
				end
				ihns_pkg::PH_NEG3: begin
					phase_d = ihns_pkg::PH_IDLE;
					res_d.done_res = 1'b1;
					if ((s & ihns_pkg::STAT_SELECT) == 8'd0) begin
						res_d.result_code = ihns_pkg::RES_SEL_LOW;
					end
				end
				ihns_pkg::PH_TRM1: begin
					ctrl_d  = ctrl_q | ihns_pkg::CTRL_AUTOFD;
					wait_d  = short_ld;
					phase_d = ihns_pkg::PH_TRM2;
				end
				ihns_pkg::PH_TRM2: begin
					ctrl_d  = ctrl_q & ~ihns_pkg::CTRL_AUTOFD;
					phase_d = ihns_pkg::PH_IDLE;
					res_d.done_res = 1'b1;
				end
				ihns_pkg::PH_NIB_HI: begin
					if (idx_q[0]) begin
						res_d.rx_byte  = {nib, lown_q};
						res_d.rx_valid = 1'b1;
					end else begin
						lown_d = nib;
					end
					idx_d   = idx_q + (COUNT_BITS+1)'(1);
					ctrl_d  = ctrl_q & ~ihns_pkg::CTRL_AUTOFD;
					wait_d  = short_ld;
					phase_d = ihns_pkg::PH_NIB_LO;
				end
				ihns_pkg::PH_NIB_LO: begin
					if (idx_q >= {tgt_q, 1'b0}) begin
						phase_d = ihns_pkg::PH_IDLE;
						res_d.done_res = 1'b1;
					end else begin
						start_nib = 1'b1;
					end
				end
				default: phase_d = ihns_pkg::PH_IDLE;
			endcase
		end

		// Raise HostBusy for the next nibble, or stop when the peripheral has no data
		if (start_nib) begin
			ctrl_d = ctrl_q | ihns_pkg::CTRL_AUTOFD;
			if (!idx_d[0] && ((s & ihns_pkg::STAT_NFAULT) != 8'd0)) begin
				phase_d = ihns_pkg::PH_IDLE;
				res_d.done_res = 1'b1;
			end else begin
				wait_d  = short_ld;
				phase_d = ihns_pkg::PH_NIB_HI;
			end
		end

		br_ext = 32'(idx_d[COUNT_BITS:1]);
		res_d.ctrl_lines = ctrl_d;
		res_d.data_lines = data_d;
		res_d.bytes_read = br_ext[15:0];
		res_d.busy_res   = (phase_d != ihns_pkg::PH_IDLE);
	end

	// Update state on each popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ihns_pkg::PH_IDLE;
			ctrl_q  <= ihns_pkg::CTRL_RESET;
			data_q  <= 8'd0;
			wait_q  <= '0;
			idx_q   <= '0;
			lown_q  <= 4'd0;
			tgt_q   <= '0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			ctrl_q  <= ctrl_d;
			data_q  <= data_d;
			wait_q  <= wait_d;
			idx_q   <= idx_d;
			lown_q  <= lown_d;
			tgt_q   <= tgt_d;
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

	`IHNS_ASSERT(a_busy_tracks_phase, q_pop |=> (res_q.busy_res == (phase_q != ihns_pkg::PH_IDLE)))
	`IHNS_ASSERT_NEVER(a_done_while_busy, out_valid_q && res_q.done_res && res_q.busy_res)
	`IHNS_ASSERT(a_rx_mid_read, (out_valid_q && res_q.rx_valid) |-> (res_q.busy_res && !res_q.done_res))
	`IHNS_ASSERT(a_reject_no_done, (out_valid_q && res_q.result_code == ihns_pkg::RES_REJ_BUSY) |-> (res_q.busy_res && !res_q.done_res))
	`IHNS_ASSERT(a_index_bound, (phase_q == ihns_pkg::PH_NIB_LO) |-> (idx_q <= {tgt_q, 1'b0}))

endmodule
